>>> rtl/ufcr_pkg.sv
`timescale 1ns / 1ps
// Package for the four-channel ultrasonic ranger: field widths, register
// indexes, reset values and the result item type. No dependencies.
package ufcr_pkg;

    localparam int SENSORS_DEF   = 4;
    localparam int ECHO_W        = 4;
    localparam int IDX_W         = 2;
    localparam int DIST_W        = 11;
    localparam int COUNT_W       = 17;
    localparam int TIMEOUT_W     = 16;
    localparam int TRIGGER_W     = 8;
    localparam int GAP_W         = 16;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 24;
    localparam int M_TUSER_W     = 2;

    // Register indexes on the configuration channel
    localparam logic [CFG_ADDR_W-1:0] REG_SCAN_ENABLE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_TICKS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_TICKS     = 2'd3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd30000;
    localparam logic [TRIGGER_W-1:0] TRIGGER_RST = 8'd10;
    localparam logic [GAP_W-1:0]     GAP_RST     = 16'd60000;

    // Rounding offset and reciprocal of 29 (2^20 scale) for the cm conversion:
    // floor((t + 29) / 58) = floor(((t + 29) >> 1) * 36158 >> 20), exact
    // for every count the echo phase can hold.
    localparam logic [COUNT_W-1:0] ROUND_OFS  = 17'd29;
    localparam logic [15:0]        RECIP_29   = 16'd36158;
    localparam int                 RECIP_SHFT = 20;

    typedef struct packed {
        logic              timed_out;
        logic [DIST_W-1:0] distance_cm;
        logic [IDX_W-1:0]  sensor_index;
        logic              result_valid;
        logic [ECHO_W-1:0] trigger_lines;
    } result_t;

endpackage

>>> rtl/ultrasonic_four_channel_ranger.sv
`timescale 1ns / 1ps
// Four-channel ultrasonic echo ranger: scan sequencer, cm conversion and a
// two-entry output buffer. Depends on ufcr_pkg.
//
// Usage:
//   Each input item on the s_ channel is one microsecond tick carrying the
//   four echo pin levels. Every accepted item yields exactly one result item
//   on the m_ channel: the trigger pin drive for that tick plus, on the tick
//   a measurement ends, the sensor index, the distance in cm or a timeout.
//   Sensors are scanned front, back, left, right while scan_enable is set;
//   each measurement is trigger pulse, wait for echo rise, count echo high,
//   then an idle gap.
//   Configuration goes through the cfg_ channel (always ready); the user must
//   write it only while the block is idle, which the block does not enforce.
//   Result path: a result item is registered into the output entry, or into
//   the skid entry while the receiver stalls. Throughput: one item per cycle
//   while s_tready is high, set by the single register stage holding the
//   sequencer state; the cm conversion is one 16x16 multiply in that same stage.
//   Stall: a result that is not taken moves into a skid register, so one
//   more item is still accepted; s_tready drops only while the skid register
//   is full, and returns as soon as the receiver takes an item.
//   Reset (aresetn low, synchronous): sequencer goes idle on sensor front,
//   counts clear, registers return to enable off, timeout 30000, trigger 10,
//   gap 60000, and both output entries empty.
module ultrasonic_four_channel_ranger
    import ufcr_pkg::*;
#(
    parameter int SENSORS = SENSORS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: [3:0] echo_levels, [7:4] zero
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // m_tdata: [3:0] trigger_lines, [5:4] sensor_index, [16:6] distance_cm,
    //          [23:17] zero
    // m_tuser: [0] result_valid, [1] timed_out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Sequencer phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_TRIG = 3'd1;
    localparam logic [2:0] PH_RISE = 3'd2;
    localparam logic [2:0] PH_HIGH = 3'd3;
    localparam logic [2:0] PH_GAP  = 3'd4;

    localparam logic [IDX_W-1:0] SENSOR_LAST = IDX_W'(SENSORS - 1);

    // Configuration registers
    logic                  scan_enable_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [TRIGGER_W-1:0]  trigger_reg;
    logic [GAP_W-1:0]      gap_reg;

    // Sequencer state
    logic [2:0]            phase_reg, phase_next;
    logic [IDX_W-1:0]      sensor_reg, sensor_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    // Output buffer
    logic                  m_valid_reg, skid_valid_reg;
    result_t               m_data_reg, skid_data_reg;

    logic                  accept;
    logic                  echo_bit;
    logic [COUNT_W-1:0]    count_inc;
    logic [COUNT_W-1:0]    round_sum;
    logic [31:0]           dist_prod;
    logic                  meas_done;
    logic [2:0]            adv_phase;
    logic [IDX_W-1:0]      adv_sensor;
    result_t               res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg.distance_cm, m_data_reg.sensor_index,
                       m_data_reg.trigger_lines};
    assign m_tuser  = {m_data_reg.timed_out, m_data_reg.result_valid};

    assign echo_bit  = s_tdata[sensor_reg];
    assign count_inc = count_reg + 1'b1;

    // Round-to-nearest cm: halve, then multiply by the reciprocal of 29
    assign round_sum = count_reg + ROUND_OFS;
    assign dist_prod = round_sum[COUNT_W-1:1] * RECIP_29;

    // Move to the next sensor, or drop to idle once scanning is switched off
    always_comb begin
        if (!scan_enable_reg) begin
            adv_phase  = PH_IDLE;
            adv_sensor = '0;
        end else begin
            adv_phase  = PH_TRIG;
            adv_sensor = (sensor_reg == SENSOR_LAST) ? '0 : sensor_reg + 1'b1;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        sensor_next = sensor_reg;
        count_next  = count_reg;
        meas_done   = 1'b0;
        res         = '0;
        case (phase_reg)
            PH_IDLE: begin
                if (scan_enable_reg) begin
                    phase_next  = PH_TRIG;
                    sensor_next = '0;
                    count_next  = '0;
                end
            end
            PH_TRIG: begin
                res.trigger_lines = ECHO_W'(1) << sensor_reg;
                count_next        = count_inc;
                if (count_inc >= {9'd0, trigger_reg}) begin
                    phase_next = PH_RISE;
                    count_next = '0;
                end
            end
            PH_RISE: begin
                if (echo_bit) begin
                    // rising tick counts as the first high tick
                    phase_next = PH_HIGH;
                    count_next = COUNT_W'(1);
                    if (timeout_reg == '0) begin
                        res.timed_out = 1'b1;
                        meas_done     = 1'b1;
                    end
                end else begin
                    count_next = count_inc;
                    if (count_inc > {1'b0, timeout_reg}) begin
                        res.timed_out = 1'b1;
                        meas_done     = 1'b1;
                    end
                end
            end
            PH_HIGH: begin
                if (echo_bit) begin
                    count_next = count_inc;
                    if (count_inc > {1'b0, timeout_reg}) begin
                        res.timed_out = 1'b1;
                        meas_done     = 1'b1;
                    end
                end else begin
                    res.distance_cm = dist_prod[RECIP_SHFT +: DIST_W];
                    meas_done       = 1'b1;
                end
            end
            PH_GAP: begin
                count_next = count_inc;
                if (count_inc >= {1'b0, gap_reg}) begin
                    phase_next  = adv_phase;
                    sensor_next = adv_sensor;
                    count_next  = '0;
                end
            end
            default: begin
                phase_next  = PH_IDLE;
                sensor_next = '0;
                count_next  = '0;
            end
        endcase

        if (meas_done) begin
            res.result_valid = 1'b1;
            res.sensor_index = sensor_reg;
            count_next       = '0;
            if (gap_reg == '0) begin
                phase_next  = adv_phase;
                sensor_next = adv_sensor;
            end else begin
                phase_next = PH_GAP;
            end
        end
    end

    // Configuration registers and sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_enable_reg <= 1'b0;
            timeout_reg     <= TIMEOUT_RST;
            trigger_reg     <= TRIGGER_RST;
            gap_reg         <= GAP_RST;
            phase_reg       <= PH_IDLE;
            sensor_reg      <= '0;
            count_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_SCAN_ENABLE:   scan_enable_reg <= cfg_data[0];
                    REG_TIMEOUT_TICKS: timeout_reg     <= cfg_data;
                    REG_TRIGGER_TICKS: trigger_reg     <= cfg_data[TRIGGER_W-1:0];
                    REG_GAP_TICKS:     gap_reg         <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                phase_reg  <= phase_next;
                sensor_reg <= sensor_next;
                count_reg  <= count_next;
            end
        end
    end

    // Output buffer control: the skid entry fills only while the output
    // entry is held by a stalled receiver
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (accept) begin
                m_data_reg <= res;
            end
        end else if (accept) begin
            skid_data_reg <= res;
        end
    end

    // The skid entry never holds an item while the output entry is empty
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry full with output entry empty");

    // At most one trigger line is driven per tick
    a_trig_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[3:0]))
        else $error("more than one trigger line driven");

    // Result fields stay zero on ticks without a finished measurement
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[16:4] == '0 && !m_tuser[1]))
        else $error("result fields set without result_valid");

    // A timeout never reports a distance
    a_tout_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[16:6] == '0 && m_tuser[0]))
        else $error("timeout reported with a distance");

endmodule
